// File: hw/rtl/obstacle_backup_sequencer_top_defines.svh
// Assertion macros shared by the sequencer RTL
`ifndef OBSTACLE_BACKUP_SEQUENCER_TOP_DEFINES_SVH
`define OBSTACLE_BACKUP_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define OBS_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked out of reset
`define OBS_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: hw/rtl/obs_seq_pkg.sv
`timescale 1ns / 1ps
package obs_seq_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] REG_WAIT_LIMIT    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RETRY_CREDIT  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_REVERSE_TICKS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TURN_TICKS    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SETTLE_TICKS  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_COMPASS_BAND  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_TURN_ANGLE    = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_DRIVE_SPEED   = 3'd7;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_REV    = 2'd1;
  localparam logic [1:0] PH_TURN   = 2'd2;
  localparam logic [1:0] PH_SETTLE = 2'd3;

  localparam logic [2:0] ST_CLEAR      = 3'd0;
  localparam logic [2:0] ST_NEW        = 3'd1;
  localparam logic [2:0] ST_WAITING    = 3'd2;
  localparam logic [2:0] ST_BACK_RIGHT = 3'd3;
  localparam logic [2:0] ST_BACK_LEFT  = 3'd4;

  localparam logic [6:0] RST_WAIT_LIMIT    = 7'd20;
  localparam logic [6:0] RST_RETRY_CREDIT  = 7'd30;
  localparam logic [3:0] RST_REVERSE_TICKS = 4'd4;
  localparam logic [3:0] RST_TURN_TICKS    = 4'd3;
  localparam logic [3:0] RST_SETTLE_TICKS  = 4'd2;
  localparam logic [7:0] RST_COMPASS_BAND  = 8'd20;
  localparam logic [6:0] RST_TURN_ANGLE    = 7'd40;
  localparam logic [2:0] RST_DRIVE_SPEED   = 3'd3;

  localparam logic signed [7:0] AGE_MAX = 8'sd127;
  localparam logic signed [7:0] AGE_MIN = -8'sd128;

  typedef struct packed {
    logic              func;
    logic              obstacle_flag;
    logic              lidar_stop;
    logic signed [8:0] heading_delta;
  } item_t;

  typedef struct packed {
    logic              stop_now;
    logic              override;
    logic signed [3:0] speed_cmd;
    logic signed [7:0] direction_cmd;
    logic              ignore_obstacle;
    logic [2:0]        status;
    logic signed [7:0] obstacle_age;
    logic              obstacle_active;
  } result_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

// File: hw/rtl/obs_seq_core.sv
`timescale 1ns / 1ps
`include "obstacle_backup_sequencer_top_defines.svh"
module obs_seq_core
  import obs_seq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_wr_t cfg,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  logic [6:0] wait_limit_r, retry_credit_r, turn_angle_r;
  logic [3:0] reverse_ticks_r, turn_ticks_r, settle_ticks_r;
  logic [7:0] compass_band_r;
  logic [2:0] drive_speed_r;

  logic              prev_r, prev_nxt;
  logic signed [7:0] age_r, age_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [3:0]        left_r, left_nxt;
  logic              tl_r, tl_nxt;

  logic              seen;
  logic signed [7:0] age_inc, age_base, age_sub;
  logic signed [8:0] age_diff;
  logic [8:0]        mag;
  logic              go_right;
  logic              escape;
  logic [2:0]        status;
  logic              stop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_limit_r    <= RST_WAIT_LIMIT;
      retry_credit_r  <= RST_RETRY_CREDIT;
      reverse_ticks_r <= RST_REVERSE_TICKS;
      turn_ticks_r    <= RST_TURN_TICKS;
      settle_ticks_r  <= RST_SETTLE_TICKS;
      compass_band_r  <= RST_COMPASS_BAND;
      turn_angle_r    <= RST_TURN_ANGLE;
      drive_speed_r   <= RST_DRIVE_SPEED;
    end else if (cfg.we) begin
      unique case (cfg.idx)
        REG_WAIT_LIMIT:    wait_limit_r    <= cfg.data[6:0];
        REG_RETRY_CREDIT:  retry_credit_r  <= cfg.data[6:0];
        REG_REVERSE_TICKS: reverse_ticks_r <= cfg.data[3:0];
        REG_TURN_TICKS:    turn_ticks_r    <= cfg.data[3:0];
        REG_SETTLE_TICKS:  settle_ticks_r  <= cfg.data[3:0];
        REG_COMPASS_BAND:  compass_band_r  <= cfg.data;
        REG_TURN_ANGLE:    turn_angle_r    <= cfg.data[6:0];
        REG_DRIVE_SPEED:   drive_speed_r   <= cfg.data[2:0];
        default: ;
      endcase
    end
  end

  assign seen     = item.obstacle_flag | item.lidar_stop;
  assign age_inc  = (age_r == AGE_MAX) ? AGE_MAX : age_r + 8'sd1;
  assign age_base = (seen && !prev_r) ? 8'sd0 : age_r;
  assign age_diff = {age_base[7], age_base} - $signed({2'b00, retry_credit_r});
  assign age_sub  = (age_diff < 9'sd0 - 9'sd128) ? AGE_MIN : age_diff[7:0];
  assign mag      = item.heading_delta[8] ? 9'(-item.heading_delta) : item.heading_delta;
  assign go_right = (mag < {1'b0, compass_band_r}) ||
                    (!item.heading_delta[8] && item.heading_delta != 9'sd0);
  assign escape   = seen && !age_base[7] && (age_base[6:0] > wait_limit_r);

  always_comb begin
    prev_nxt  = prev_r;
    age_nxt   = age_r;
    phase_nxt = phase_r;
    left_nxt  = left_r;
    tl_nxt    = tl_r;
    status    = ST_CLEAR;
    stop      = 1'b0;
    if (item.func == FUNC_TICK) begin
      age_nxt = age_inc;
      if (phase_r != PH_IDLE) begin
        if (left_r > 4'd1) begin
          left_nxt = left_r - 4'd1;
        end else begin
          unique case (phase_r)
            PH_REV: begin
              phase_nxt = PH_TURN;
              left_nxt  = turn_ticks_r;
            end
            PH_TURN: begin
              phase_nxt = PH_SETTLE;
              left_nxt  = settle_ticks_r;
            end
            default: begin
              phase_nxt = PH_IDLE;
              left_nxt  = 4'd0;
            end
          endcase
        end
      end else begin
        status = prev_r ? ST_WAITING : ST_CLEAR;
      end
    end else begin
      stop = item.lidar_stop;
      if (phase_r == PH_IDLE) begin
        age_nxt = age_base;
        if (seen && !prev_r) status = ST_NEW;
        if (escape) begin
          age_nxt   = age_sub;
          tl_nxt    = !go_right;
          phase_nxt = PH_REV;
          left_nxt  = reverse_ticks_r;
        end else if (seen && prev_r) begin
          status = ST_WAITING;
        end
        prev_nxt = seen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      age_r   <= 8'sd0;
      phase_r <= PH_IDLE;
      left_r  <= 4'd0;
      tl_r    <= 1'b0;
    end else if (fire) begin
      prev_r  <= prev_nxt;
      age_r   <= age_nxt;
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      tl_r    <= tl_nxt;
    end
  end

  always_comb begin
    res                 = '0;
    res.stop_now        = stop;
    res.override        = (phase_nxt != PH_IDLE);
    res.ignore_obstacle = (phase_nxt != PH_IDLE);
    res.status          = status;
    res.obstacle_age    = age_nxt;
    res.obstacle_active = prev_nxt;
    if (phase_nxt != PH_IDLE) begin
      res.status = tl_nxt ? ST_BACK_LEFT : ST_BACK_RIGHT;
      if (phase_nxt == PH_REV) begin
        res.speed_cmd = 4'sd0 - $signed({1'b0, drive_speed_r});
      end else if (phase_nxt == PH_TURN) begin
        res.speed_cmd     = $signed({1'b0, drive_speed_r});
        res.direction_cmd = tl_nxt ? 8'sd0 - $signed({1'b0, turn_angle_r})
                                   : $signed({1'b0, turn_angle_r});
      end
    end
  end

  `OBS_ASSERT_IMP(a_idle_no_count, phase_r == PH_IDLE, left_r == 4'd0, "idle with ticks left")
  `OBS_ASSERT_NXT(a_escape_holds_track,
    fire && item.func == FUNC_SAMPLE && phase_r != PH_IDLE,
    prev_r == $past(prev_r) && age_r == $past(age_r), "sample changed tracking during escape")
  `OBS_ASSERT_IMP(a_override_status, res.override,
    res.status == ST_BACK_RIGHT || res.status == ST_BACK_LEFT, "escape without backing status")

endmodule

// File: hw/rtl/obstacle_backup_sequencer_top.sv
// An accepted word passes through the input stage, then the result register.
// Throughput: one word per cycle; input stage and result register keep flowing while
// the result side takes a word every cycle.
// Reset: synchronous active-low rst_n clears both stages, the tracking state and
// loads the register defaults; no clearing pass follows.
`timescale 1ns / 1ps
`include "obstacle_backup_sequencer_top_defines.svh"
module obstacle_backup_sequencer_top
  import obs_seq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic                in_obstacle_flag,
  input  logic                in_lidar_stop,
  input  logic signed [8:0]   in_heading_delta,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_stop_now,
  output logic                out_override,
  output logic signed [3:0]   out_speed_cmd,
  output logic signed [7:0]   out_direction_cmd,
  output logic                out_ignore_obstacle,
  output logic [2:0]          out_status,
  output logic signed [7:0]   out_obstacle_age,
  output logic                out_obstacle_active
);

  logic    stg_vld_r, stg_vld_nxt;
  item_t   stg_r;
  logic    out_vld_r, out_vld_nxt;
  result_t out_r;
  result_t res;
  cfg_wr_t cfg;
  logic    adv, fire, take;

  assign adv      = !out_vld_r || out_ready;
  assign fire     = stg_vld_r && adv;
  assign in_ready = !stg_vld_r || adv;
  assign take     = in_valid && in_ready;

  assign cfg.we   = cfg_we;
  assign cfg.idx  = cfg_idx;
  assign cfg.data = cfg_data;

  assign stg_vld_nxt = take ? 1'b1 : (fire ? 1'b0 : stg_vld_r);
  assign out_vld_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg_r.func          <= in_func;
      stg_r.obstacle_flag <= in_obstacle_flag;
      stg_r.lidar_stop    <= in_lidar_stop;
      stg_r.heading_delta <= in_heading_delta;
    end
    if (fire) out_r <= res;
  end

  obs_seq_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .cfg  (cfg),
    .fire (fire),
    .item (stg_r),
    .res  (res)
  );

  assign out_valid           = out_vld_r;
  assign out_stop_now        = out_r.stop_now;
  assign out_override        = out_r.override;
  assign out_speed_cmd       = out_r.speed_cmd;
  assign out_direction_cmd   = out_r.direction_cmd;
  assign out_ignore_obstacle = out_r.ignore_obstacle;
  assign out_status          = out_r.status;
  assign out_obstacle_age    = out_r.obstacle_age;
  assign out_obstacle_active = out_r.obstacle_active;

  `OBS_ASSERT_IMP(a_stall_cause, !in_ready,
    stg_vld_r && out_vld_r && !out_ready, "input stalled without cause")
  `OBS_ASSERT_NXT(a_fire_fills_out, fire, out_vld_r, "advanced word not presented")
  `OBS_ASSERT_NXT(a_out_hold, out_vld_r && !out_ready,
    out_vld_r && $stable(out_r), "result word changed while stalled")

endmodule
